[design/rtd_pkg.sv]
// Shared types, widths and fixed-point constants of the RTD code to temperature block.
// No dependencies; every other design file refers to this package by scoped names.
package rtd_pkg;

    localparam int RAW_W   = 16;
    localparam int CODE_W  = 15;
    localparam int CFG_W   = 16;
    localparam int N_W     = 31;
    localparam int X_W     = 34;
    localparam int NLO_W   = X_W - 15;
    localparam int RTOP_W  = N_W - NLO_W;
    localparam int REM_W   = 16;
    localparam int K_W     = 29;
    localparam int XLO_W   = 17;
    localparam int PP_W    = K_W + XLO_W;
    localparam int PROD_W  = K_W + X_W;
    localparam int ARG_W   = 62;
    localparam int ROOT_W  = 31;
    localparam int CSQ_W   = 31;
    localparam int TV_W    = 32;
    localparam int U_W     = 31;
    localparam int MAG_W   = 34;
    localparam int MLO_W   = 17;
    localparam int PL_W    = MLO_W + U_W;
    localparam int ACC_W   = 36;
    localparam int TEMP_W  = 20;

    localparam int DIV_STAGES   = 34;
    localparam int ROOT_STAGES  = 31;
    localparam int HORNER_STEPS = 5;
    localparam int SQRT_LAT     = 2 + ROOT_STAGES + 1;
    localparam int POLY_LAT     = 1 + 3 * HORNER_STEPS + 1;
    localparam int POLY_ALIGN   = SQRT_LAT - POLY_LAT;

    localparam logic [CFG_W-1:0] REF_RES_RESET = 16'd430;
    localparam logic [CFG_W-1:0] NOM_RES_RESET = 16'd100;

    localparam logic signed [ACC_W-1:0] TEMP_HI = 36'sd524287;
    localparam logic signed [ACC_W-1:0] TEMP_LO = -36'sd131072;

    typedef enum logic {
        REG_REF_RES = 1'b0,
        REG_NOM_RES = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic neg;       // negative root argument or quotient overflow
        logic sel_poly;  // root form went below zero, take the polynomial
    } sqrt_status_t;

    // round(num * 2^sh / den), restoring long division at elaboration
    function automatic logic [127:0] cdiv_round(input logic [127:0] num,
                                                input logic [127:0] den,
                                                input int sh);
        logic [127:0] dvd;
        logic [127:0] rem;
        logic [127:0] q;
        dvd = num << sh;
        rem = '0;
        q   = '0;
        for (int i = 127; i >= 0; i--)
        begin
            rem = {rem[126:0], dvd[i]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        if ({rem[126:0], 1'b0} >= den)
            q = q + 128'd1;
        return q;
    endfunction

    localparam logic [ARG_W-1:0] C0_ARG =
        ARG_W'(cdiv_round(128'd6394475960000, 128'd121275, 36));
    localparam logic [K_W-1:0] K_SLOPE =
        K_W'(cdiv_round(128'd840000000000, 128'd121275, 6));
    localparam logic [CSQ_W-1:0] C_HALF =
        CSQ_W'(cdiv_round(128'd142120, 128'd21, 18));

    // Horner coefficients in order of use, sign included, 24 fraction bits
    function automatic logic signed [ACC_W-1:0] horner_coef(input int step);
        logic [ACC_W-1:0] mag;
        logic             neg;
        mag = '0;
        neg = 1'b0;
        case (step)
            0: mag = ACC_W'(cdiv_round(128'd15243, 128'd100000000000000, 59));
            1: begin
                mag = ACC_W'(cdiv_round(128'd28183, 128'd1000000000000, 52));
                neg = 1'b1;
            end
            2: begin
                mag = ACC_W'(cdiv_round(128'd48260, 128'd10000000000, 45));
                neg = 1'b1;
            end
            3: mag = ACC_W'(cdiv_round(128'd25859, 128'd10000000, 38));
            4: mag = ACC_W'(cdiv_round(128'd22228, 128'd10000, 31));
            default: begin
                mag = ACC_W'(cdiv_round(128'd24202, 128'd100, 24));
                neg = 1'b1;
            end
        endcase
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

[design/rtd_code_to_temperature.sv]
// RTD converter code to temperature: Callendar-Van Dusen inverse, fully pipelined.
// Accepts one item per cycle.
// The rate is set by the pipeline alone: a 34-stage divider, a 31-stage root, a Horner chain.
// busy stays low; the receiver cannot stall and the pipeline never holds.
// Reset clears the valid line and loads ref_resistance 430, nominal_resistance 100.
// Depends on rtd_pkg, rtd_sqrt_path, rtd_poly.
module rtd_code_to_temperature #(
    parameter int TEMP_FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rtd_pkg::RAW_W-1:0]         raw_word,
    output logic                              done,
    output logic signed [rtd_pkg::TEMP_W-1:0] temperature,
    output logic                              out_of_range,
    input  logic                              cfg_we,
    input  rtd_pkg::cfg_reg_t                 cfg_index,
    input  logic [rtd_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int LAT = 3 + rtd_pkg::DIV_STAGES + rtd_pkg::SQRT_LAT + 1;

    // Configuration registers
    logic [rtd_pkg::CFG_W-1:0] ref_res_reg;
    logic [rtd_pkg::CFG_W-1:0] nom_res_reg;
    logic [rtd_pkg::CFG_W-1:0] nom_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_res_reg <= rtd_pkg::REF_RES_RESET;
            nom_res_reg <= rtd_pkg::NOM_RES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtd_pkg::REG_REF_RES: ref_res_reg <= cfg_wdata;
                rtd_pkg::REG_NOM_RES: nom_res_reg <= cfg_wdata;
            endcase
        end
    end

    // A zero nominal resistance acts as one ohm
    assign nom_eff = (nom_res_reg == '0) ? rtd_pkg::CFG_W'(1) : nom_res_reg;

    // Valid line: one bit per pipeline register, cleared by reset
    logic [LAT-1:0] valid_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], start & ~busy};
    end

    // Capture the ratio, drop the fault bit
    logic [rtd_pkg::CODE_W-1:0] code_reg;
    logic [rtd_pkg::N_W-1:0]    n_reg;

    always_ff @(posedge clk)
    begin
        code_reg <= raw_word[rtd_pkg::RAW_W-1:1];
        // Rt with 15 fraction bits
        n_reg    <= {{(rtd_pkg::N_W - rtd_pkg::CODE_W){1'b0}}, code_reg} *
                    {{(rtd_pkg::N_W - rtd_pkg::CFG_W){1'b0}}, ref_res_reg};
    end

    // Divider x = floor(n * 2^15 / R0): the top bits seed the remainder,
    // overflow (x >= 2^34) is decided up front, then one quotient bit a stage.
    logic [rtd_pkg::REM_W-1:0] drem_reg [rtd_pkg::DIV_STAGES+1];
    logic [rtd_pkg::X_W-1:0]   dq_reg   [rtd_pkg::DIV_STAGES+1];
    logic [rtd_pkg::NLO_W-1:0] dlo_reg  [rtd_pkg::NLO_W];
    logic                      dovf_reg [rtd_pkg::DIV_STAGES+1];

    always_ff @(posedge clk)
    begin
        dovf_reg[0] <= {4'b0, n_reg} >= {nom_eff, {rtd_pkg::NLO_W{1'b0}}};
        drem_reg[0] <= {{(rtd_pkg::REM_W - rtd_pkg::RTOP_W){1'b0}},
                        n_reg[rtd_pkg::N_W-1:rtd_pkg::NLO_W]};
        dlo_reg[0]  <= n_reg[rtd_pkg::NLO_W-1:0];
        dq_reg[0]   <= '0;
    end

    for (genvar j = 0; j < rtd_pkg::DIV_STAGES; j++)
    begin : g_div
        logic                      bit_in;
        logic [rtd_pkg::REM_W:0]   trial;
        logic [rtd_pkg::REM_W:0]   diff;
        logic                      ge;

        if (j < rtd_pkg::NLO_W)
        begin : g_data
            assign bit_in = dlo_reg[j][rtd_pkg::NLO_W-1-j];

            // carry the low dividend bits only while some are left to bring down
            if (j + 1 < rtd_pkg::NLO_W)
            begin : g_fwd
                always_ff @(posedge clk)
                begin
                    dlo_reg[j+1] <= dlo_reg[j];
                end
            end
        end
        else
        begin : g_zero
            assign bit_in = 1'b0;
        end

        assign trial = {drem_reg[j], bit_in};
        assign ge    = trial >= {1'b0, nom_eff};
        assign diff  = trial - {1'b0, nom_eff};

        always_ff @(posedge clk)
        begin
            drem_reg[j+1] <= ge ? diff[rtd_pkg::REM_W-1:0] : trial[rtd_pkg::REM_W-1:0];
            dq_reg[j+1]   <= {dq_reg[j][rtd_pkg::X_W-2:0], ge};
            dovf_reg[j+1] <= dovf_reg[j];
        end
    end

    // Both branches work on every item; the root form decides which one counts
    logic signed [rtd_pkg::ACC_W-1:0] t_sqrt;
    logic signed [rtd_pkg::ACC_W-1:0] t_poly;
    rtd_pkg::sqrt_status_t            sq_status;

    rtd_sqrt_path #(
        .TEMP_FRAC_BITS(TEMP_FRAC_BITS)
    ) u_sqrt (
        .clk    (clk),
        .x      (dq_reg[rtd_pkg::DIV_STAGES]),
        .ovf    (dovf_reg[rtd_pkg::DIV_STAGES]),
        .t_sqrt (t_sqrt),
        .status (sq_status)
    );

    rtd_poly #(
        .TEMP_FRAC_BITS(TEMP_FRAC_BITS)
    ) u_poly (
        .clk    (clk),
        .x      (dq_reg[rtd_pkg::DIV_STAGES]),
        .t_poly (t_poly)
    );

    // Hold the shorter polynomial result until the root result catches up
    logic signed [rtd_pkg::ACC_W-1:0] pdly_reg [rtd_pkg::POLY_ALIGN];

    always_ff @(posedge clk)
    begin
        pdly_reg[0] <= t_poly;
        for (int i = 1; i < rtd_pkg::POLY_ALIGN; i++)
            pdly_reg[i] <= pdly_reg[i-1];
    end

    // Select, clamp and flag
    logic signed [rtd_pkg::ACC_W-1:0]  t_sel;
    logic signed [rtd_pkg::TEMP_W-1:0] temp_next;
    logic                              flag_next;
    logic signed [rtd_pkg::TEMP_W-1:0] temp_reg;
    logic                              flag_reg;

    always_comb
    begin
        t_sel = sq_status.sel_poly ? pdly_reg[rtd_pkg::POLY_ALIGN-1] : t_sqrt;
        priority if (sq_status.neg)
        begin
            temp_next = rtd_pkg::TEMP_W'(rtd_pkg::TEMP_HI);
            flag_next = 1'b1;
        end
        else if (t_sel > rtd_pkg::TEMP_HI)
        begin
            temp_next = rtd_pkg::TEMP_W'(rtd_pkg::TEMP_HI);
            flag_next = 1'b1;
        end
        else if (t_sel < rtd_pkg::TEMP_LO)
        begin
            temp_next = rtd_pkg::TEMP_W'(rtd_pkg::TEMP_LO);
            flag_next = 1'b1;
        end
        else
        begin
            temp_next = rtd_pkg::TEMP_W'(t_sel);
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg <= temp_next;
        flag_reg <= flag_next;
    end

    assign temperature  = temp_reg;
    assign out_of_range = flag_reg;
    assign done         = valid_reg[LAT-1];

`ifndef SYNTHESIS
    // a flagged item always sits at one end of the range
    a_flag_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |->
        (temperature == rtd_pkg::TEMP_W'(rtd_pkg::TEMP_HI) ||
         temperature == rtd_pkg::TEMP_W'(rtd_pkg::TEMP_LO)))
        else $error("flagged item not saturated");

    // without overflow the divider remainder stays below the divisor
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2 + rtd_pkg::DIV_STAGES] && !dovf_reg[rtd_pkg::DIV_STAGES]) |->
        (drem_reg[rtd_pkg::DIV_STAGES] < nom_eff))
        else $error("divider remainder out of range");

    // every accepted item leaves after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item lost in the pipeline");
`endif

endmodule

[design/rtd_sqrt_path.sv]
// Square-root branch: argument C0 - K*x, pipelined integer root, rescale of C - s.
// Depends on rtd_pkg.
module rtd_sqrt_path #(
    parameter int TEMP_FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic [rtd_pkg::X_W-1:0]          x,
    input  logic                             ovf,
    output logic signed [rtd_pkg::ACC_W-1:0] t_sqrt,
    output rtd_pkg::sqrt_status_t            status
);

    localparam int SH = 19 - TEMP_FRAC_BITS;
    localparam logic signed [rtd_pkg::TV_W-1:0] BIAS =
        rtd_pkg::TV_W'(1) << (SH - 1);

    // product stage
    logic [rtd_pkg::PP_W-1:0] plo_reg;
    logic [rtd_pkg::PP_W-1:0] phi_reg;
    logic                     ovf1_reg;

    always_ff @(posedge clk)
    begin
        plo_reg  <= rtd_pkg::PP_W'(rtd_pkg::K_SLOPE) *
                    rtd_pkg::PP_W'(x[rtd_pkg::XLO_W-1:0]);
        phi_reg  <= rtd_pkg::PP_W'(rtd_pkg::K_SLOPE) *
                    rtd_pkg::PP_W'(x[rtd_pkg::X_W-1:rtd_pkg::XLO_W]);
        ovf1_reg <= ovf;
    end

    // argument stage
    logic [rtd_pkg::PROD_W-1:0] prod;
    logic [rtd_pkg::ARG_W-1:0]  rem_reg [rtd_pkg::ROOT_STAGES];
    logic [rtd_pkg::ARG_W-1:0]  res_reg [rtd_pkg::ROOT_STAGES+1];
    logic                       neg_reg [rtd_pkg::ROOT_STAGES+1];

    assign prod = {phi_reg, {rtd_pkg::XLO_W{1'b0}}} +
                  {{rtd_pkg::XLO_W{1'b0}}, plo_reg};

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= ovf1_reg |
                      (prod > rtd_pkg::PROD_W'(rtd_pkg::C0_ARG));
        rem_reg[0] <= rtd_pkg::C0_ARG - prod[rtd_pkg::ARG_W-1:0];
        res_reg[0] <= '0;
    end

    // one root digit per stage
    for (genvar i = 0; i < rtd_pkg::ROOT_STAGES; i++)
    begin : g_root
        localparam logic [rtd_pkg::ARG_W-1:0] BITV =
            rtd_pkg::ARG_W'(1) << (rtd_pkg::ARG_W - 2 - 2 * i);
        logic [rtd_pkg::ARG_W-1:0] trial;
        logic                      ge;

        assign trial = res_reg[i] + BITV;
        assign ge    = rem_reg[i] >= trial;

        always_ff @(posedge clk)
        begin
            res_reg[i+1] <= ge ? (res_reg[i] >> 1) + BITV : res_reg[i] >> 1;
            neg_reg[i+1] <= neg_reg[i];
        end

        // the last digit needs no remainder after it
        if (i + 1 < rtd_pkg::ROOT_STAGES)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[i+1] <= ge ? rem_reg[i] - trial : rem_reg[i];
            end
        end
    end

    // C - s, rounded to the output fraction
    logic signed [rtd_pkg::TV_W-1:0]  tv;
    logic signed [rtd_pkg::TV_W-1:0]  tr;
    logic signed [rtd_pkg::ACC_W-1:0] t_sqrt_reg;
    rtd_pkg::sqrt_status_t            status_reg;

    assign tv = $signed({1'b0, rtd_pkg::C_HALF}) -
                $signed({{(rtd_pkg::TV_W - rtd_pkg::ROOT_W){1'b0}},
                         res_reg[rtd_pkg::ROOT_STAGES][rtd_pkg::ROOT_W-1:0]});
    assign tr = (tv + BIAS) >>> SH;

    always_ff @(posedge clk)
    begin
        t_sqrt_reg          <= rtd_pkg::ACC_W'(tr);
        status_reg.sel_poly <= tv[rtd_pkg::TV_W-1];
        status_reg.neg      <= neg_reg[rtd_pkg::ROOT_STAGES];
    end

    assign t_sqrt = t_sqrt_reg;
    assign status = status_reg;

endmodule

[design/rtd_poly.sv]
// Fifth-order polynomial branch for temperatures below zero, Horner form, 3 stages per step.
// Depends on rtd_pkg.
module rtd_poly #(
    parameter int TEMP_FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic [rtd_pkg::X_W-1:0]          x,
    output logic signed [rtd_pkg::ACC_W-1:0] t_poly
);

    localparam int SH = 24 - TEMP_FRAC_BITS;
    localparam logic signed [rtd_pkg::ACC_W-1:0] BIAS =
        rtd_pkg::ACC_W'(1) << (SH - 1);
    localparam int UX_W = rtd_pkg::X_W + 7;

    logic [UX_W-1:0]                  ux;
    logic signed [rtd_pkg::ACC_W-1:0] acc_reg [rtd_pkg::HORNER_STEPS+1];
    logic [rtd_pkg::U_W-1:0]          u_reg   [rtd_pkg::HORNER_STEPS];

    // scale to a 100-ohm element: u = (100 x + 64) >> 7
    assign ux = {7'b0, x} * UX_W'(100) + UX_W'(64);

    always_ff @(posedge clk)
    begin
        u_reg[0]   <= ux[7 +: rtd_pkg::U_W];
        acc_reg[0] <= rtd_pkg::horner_coef(0);
    end

    for (genvar k = 0; k < rtd_pkg::HORNER_STEPS; k++)
    begin : g_step
        localparam logic signed [rtd_pkg::ACC_W-1:0] COEF = rtd_pkg::horner_coef(k + 1);
        logic                      sgn_a_reg;
        logic [rtd_pkg::MAG_W-1:0] mag_reg;
        logic [rtd_pkg::U_W-1:0]   ua_reg;
        logic                      sgn_b_reg;
        logic [rtd_pkg::PL_W-1:0]  plo_reg;
        logic [rtd_pkg::PL_W-1:0]  phi_reg;
        logic [rtd_pkg::PL_W+rtd_pkg::MLO_W-1:0] sum;
        logic [rtd_pkg::ACC_W-1:0] pe;

        assign sum = {phi_reg, {rtd_pkg::MLO_W{1'b0}}} +
                     {{rtd_pkg::MLO_W{1'b0}}, plo_reg} +
                     (rtd_pkg::PL_W + rtd_pkg::MLO_W)'(1 << 29);
        assign pe  = {1'b0, sum[30 +: rtd_pkg::ACC_W-1]};

        always_ff @(posedge clk)
        begin
            // magnitude and sign
            sgn_a_reg <= acc_reg[k][rtd_pkg::ACC_W-1];
            mag_reg   <= acc_reg[k][rtd_pkg::ACC_W-1] ?
                         rtd_pkg::MAG_W'(-acc_reg[k]) : rtd_pkg::MAG_W'(acc_reg[k]);
            ua_reg    <= u_reg[k];
            // partial products
            sgn_b_reg <= sgn_a_reg;
            plo_reg   <= rtd_pkg::PL_W'(mag_reg[rtd_pkg::MLO_W-1:0]) * rtd_pkg::PL_W'(ua_reg);
            phi_reg   <= rtd_pkg::PL_W'(mag_reg[rtd_pkg::MAG_W-1:rtd_pkg::MLO_W]) *
                         rtd_pkg::PL_W'(ua_reg);
            // round half away from zero and add the next coefficient
            acc_reg[k+1] <= sgn_b_reg ? COEF - $signed(pe) : COEF + $signed(pe);
        end

        // advance u alongside the accumulator; the last step passes nothing on
        if (k + 1 < rtd_pkg::HORNER_STEPS)
        begin : g_fwd
            logic [rtd_pkg::U_W-1:0] ub_reg;

            always_ff @(posedge clk)
            begin
                ub_reg     <= ua_reg;
                u_reg[k+1] <= ub_reg;
            end
        end
    end

    logic signed [rtd_pkg::ACC_W-1:0] t_poly_reg;

    always_ff @(posedge clk)
    begin
        t_poly_reg <= (acc_reg[rtd_pkg::HORNER_STEPS] + BIAS) >>> SH;
    end

    assign t_poly = t_poly_reg;

endmodule

[dv/rtd_code_to_temperature_checker.sv]
// Checker for the RTD code to temperature block: watches the command and result
// channels and the register port, predicts each temperature and compares it.
// Depends on rtd_pkg for the register index type, the port widths and the reset values.
module rtd_code_to_temperature_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [rtd_pkg::RAW_W-1:0]         raw_word,
    input  logic                              done,
    input  logic signed [rtd_pkg::TEMP_W-1:0] temperature,
    input  logic                              out_of_range,
    input  logic                              cfg_we,
    input  rtd_pkg::cfg_reg_t                 cfg_index,
    input  logic [rtd_pkg::CFG_W-1:0]         cfg_wdata,
    output int                                errors,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam longint TMAX = 524287;
    localparam longint TMIN = -131072;

    typedef struct {
        logic signed [19:0] temp;
        logic               flag;
    } temp_result_t;

    temp_result_t         temps_due[$];
    logic [15:0]          ref_res;
    logic [15:0]          nom_res;

    // round(num * 2^sh / den)
    function automatic logic [127:0] round_div(logic [127:0] num, logic [127:0] den, int sh);
        logic [127:0] q;
        logic [127:0] r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < sh; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                q[0] = 1'b1;
                r = r - den;
            end
        end
        if ((r << 1) >= den)
            q = q + 1;
        return q;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // acc * u / 2^30, half away from zero
    function automatic longint horner_mul(longint acc, logic [63:0] u);
        logic [127:0] m;
        logic [127:0] p;
        m = (acc < 0) ? 128'(-acc) : 128'(acc);
        p = (m * u + (128'd1 << 29)) >> 30;
        return (acc < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic temp_result_t predict_temperature(logic [15:0] word,
                                                         logic [15:0] rref,
                                                         logic [15:0] rnom);
        temp_result_t res;
        logic [63:0]  code;
        logic [63:0]  nom;
        logic [63:0]  x;
        logic [63:0]  c0;
        logic [63:0]  kslope;
        logic [63:0]  s;
        logic [63:0]  u;
        longint       tv;
        longint       acc;
        longint       t;
        code   = word >> 1;
        nom    = (rnom == 0) ? 64'd1 : 64'(rnom);
        x      = ((code * rref) << 15) / nom;
        c0     = 64'(round_div(128'd6394475960000, 128'd121275, 36));
        kslope = 64'(round_div(128'd840000000000, 128'd121275, 6));
        res.flag = 1'b0;
        if (x >= (64'd1 << 34) || kslope * x > c0)
        begin
            t = TMAX;
            res.flag = 1'b1;
        end
        else
        begin
            s  = int_sqrt(c0 - kslope * x);
            tv = longint'(round_div(128'd142120, 128'd21, 18)) - longint'(s);
            if (tv >= 0)
                t = (tv + (64'sd1 << (18 - FRAC))) >>> (19 - FRAC);
            else
            begin
                // below zero: fifth-order polynomial in r/128
                u   = (100 * x + 64) >> 7;
                acc = longint'(round_div(128'd15243, 128'd100000000000000, 59));
                acc = horner_mul(acc, u)
                    - longint'(round_div(128'd28183, 128'd1000000000000, 52));
                acc = horner_mul(acc, u)
                    - longint'(round_div(128'd48260, 128'd10000000000, 45));
                acc = horner_mul(acc, u) + longint'(round_div(128'd25859, 128'd10000000, 38));
                acc = horner_mul(acc, u) + longint'(round_div(128'd22228, 128'd10000, 31));
                acc = horner_mul(acc, u) - longint'(round_div(128'd24202, 128'd100, 24));
                t = (acc + (64'sd1 << (23 - FRAC))) >>> (24 - FRAC);
            end
            if (t > TMAX)
            begin
                t = TMAX;
                res.flag = 1'b1;
            end
            if (t < TMIN)
            begin
                t = TMIN;
                res.flag = 1'b1;
            end
        end
        res.temp = 20'(t);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t checker: %s", $realtime, what);
        errors++;
    endtask

    initial
    begin
        errors = 0;
    end

    assign pending = temps_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        temp_result_t want;
        if (!rst_n)
        begin
            ref_res = rtd_pkg::REF_RES_RESET;
            nom_res = rtd_pkg::NOM_RES_RESET;
            temps_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (temps_due.size() == 0)
                    report_mismatch("temperature with no item outstanding");
                else
                begin
                    want = temps_due.pop_front();
                    if (temperature !== want.temp)
                        report_mismatch($sformatf("temperature %0d, want %0d",
                                                  temperature, want.temp));
                    if (out_of_range !== want.flag)
                        report_mismatch($sformatf("out_of_range %b, want %b",
                                                  out_of_range, want.flag));
                end
            end
            if (start && !busy)
                temps_due.push_back(predict_temperature(raw_word, ref_res, nom_res));
            if (cfg_we)
            begin
                if (cfg_index == rtd_pkg::REG_REF_RES)
                    ref_res = cfg_wdata;
                else
                    nom_res = cfg_wdata;
            end
        end
    end
endmodule

[dv/tb_rtd_code_to_temperature.sv]
// Top of the RTD code to temperature testbench: clock, reset, register phases and
// command items; the checker beside the block does all prediction and comparison.
// Depends on rtd_pkg, rtd_code_to_temperature and rtd_code_to_temperature_checker.
module tb_rtd_code_to_temperature;
    timeunit 1ns;
    timeprecision 1ps;

    // settle beyond the pipeline latency after each drain
    localparam int SETTLE     = 90;
    localparam int CYCLE_CAP  = 300000;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [rtd_pkg::RAW_W-1:0]         raw_word;
    logic                              done;
    logic signed [rtd_pkg::TEMP_W-1:0] temperature;
    logic                              out_of_range;
    logic                              cfg_we;
    rtd_pkg::cfg_reg_t                 cfg_index;
    logic [rtd_pkg::CFG_W-1:0]         cfg_wdata;
    int                                errors;
    int                                pending;
    int                                cycles;

    rtd_code_to_temperature i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .raw_word     (raw_word),
        .done         (done),
        .temperature  (temperature),
        .out_of_range (out_of_range),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    rtd_code_to_temperature_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .raw_word     (raw_word),
        .done         (done),
        .temperature  (temperature),
        .out_of_range (out_of_range),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop if the pipeline hangs
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_CAP)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // codes mostly across the sensor's working span, some near zero, the rest anywhere
    function automatic logic [15:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 16'($urandom_range(24000, 2000));
        if (roll < 80)
            return 16'($urandom_range(700, 0));
        return 16'($urandom());
    endfunction

    // hand one item over; hold start high if the next one follows at once
    task automatic send_item(logic [15:0] word, bit back_to_back);
        int gap;
        start    <= 1'b1;
        raw_word <= word;
        do
            @(posedge clk);
        while (busy);
        gap = back_to_back ? 0 : pick_gap();
        if (gap > 0)
        begin
            start    <= 1'b0;
            raw_word <= 16'($urandom());
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop start, drain the pipeline, then let it settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(rtd_pkg::cfg_reg_t idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    logic [15:0] ref_set[8] = '{16'd430, 16'd430, 16'd4000, 16'd65535,
                                16'd1, 16'd0, 16'd400, 16'd430};
    logic [15:0] nom_set[8] = '{16'd100, 16'd1000, 16'd1000, 16'd1,
                                16'd65535, 16'd100, 16'd0, 16'd100};
    logic [15:0] directed[20] = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF,
                                  16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
                                  16'd15240, 16'd15241, 16'd15238, 16'd15242,
                                  16'd4000, 16'd8000, 16'd30000, 16'd40000,
                                  16'd2, 16'd100, 16'd60000, 16'd24000};

    initial
    begin
        int burst;
        rst_n     = 1'b0;
        start     = 1'b0;
        raw_word  = '0;
        cfg_we    = 1'b0;
        cfg_index = rtd_pkg::REG_REF_RES;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, directed corners included
        foreach (directed[i])
            send_item(directed[i], 1'b0);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            if (p < 8)
            begin
                write_reg(rtd_pkg::REG_REF_RES, ref_set[p]);
                write_reg(rtd_pkg::REG_NOM_RES, nom_set[p]);
            end
            else
            begin
                write_reg(rtd_pkg::REG_REF_RES, 16'($urandom_range(65535, 1)));
                write_reg(rtd_pkg::REG_NOM_RES, 16'($urandom_range(65535, 1)));
            end
            for (int n = 0; n < 170; n++)
            begin
                // occasional back-to-back bursts keep start high across items
                burst = ($urandom_range(9) == 0) ? 1 : 0;
                send_item(pick_word(), burst[0]);
            end
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[filelist.f]
design/rtd_pkg.sv
design/rtd_sqrt_path.sv
design/rtd_poly.sv
design/rtd_code_to_temperature.sv
dv/rtd_code_to_temperature_checker.sv
dv/tb_rtd_code_to_temperature.sv
